>>> rtl/ort_pkg.sv
// ----------------------------------------------------------------------------
// ort_pkg - ordered record table package
// record layout, request and status codes, control state and cell commands
// ----------------------------------------------------------------------------
`default_nettype none

package ort_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int ID_W            = 32;
    localparam int TOKEN_W         = 64;
    localparam int AGE_W           = 8;
    localparam int POS_W           = 8;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [TOKEN_W-1:0] name;
        logic               gender;
        logic [AGE_W-1:0]   age;
        logic [TOKEN_W-1:0] major;
    } record_t;

    typedef enum logic [2:0] {
        REQ_APPEND = 3'd0,
        REQ_INSERT = 3'd1,
        REQ_DELETE = 3'd2,
        REQ_SEARCH = 3'd3,
        REQ_MODIFY = 3'd4,
        REQ_PRINT  = 3'd5
    } req_code_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_POS   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_PRINT
    } ctrl_state_t;

    // command broadcast to every cell of the row
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_INSERT,
        CELL_DELETE
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        record_t  rec;
    } cell_cmd_t;

    typedef struct packed {
        status_t status;
        record_t rec;
        logic    last;
    } result_t;

endpackage : ort_pkg

`default_nettype wire

>>> rtl/ort_if.sv
// ----------------------------------------------------------------------------
// ort_if - ordered record table channels
// request and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface ort_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [31:0] record_id;
    logic [31:0] new_id;
    logic [63:0] name_token;
    logic        gender_code;
    logic [7:0]  age_value;
    logic [63:0] major_token;
    logic [7:0]  position;

    modport source (
        output valid, req_type, record_id, new_id, name_token, gender_code,
               age_value, major_token, position,
        input  ready
    );

    modport sink (
        input  valid, req_type, record_id, new_id, name_token, gender_code,
               age_value, major_token, position,
        output ready
    );
endinterface : ort_req_if

interface ort_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] out_id;
    logic [63:0] out_name;
    logic        out_gender;
    logic [7:0]  out_age;
    logic [63:0] out_major;
    logic        last_flag;

    modport source (
        output valid, status, out_id, out_name, out_gender, out_age,
               out_major, last_flag,
        input  ready
    );

    modport sink (
        input  valid, status, out_id, out_name, out_gender, out_age,
               out_major, last_flag,
        output ready
    );
endinterface : ort_rsp_if

`default_nettype wire

>>> rtl/ordered_record_table.sv
// ----------------------------------------------------------------------------
// ordered_record_table - ordered table of records in a row of cells
// append, positional insert, delete/search/modify by id, print all
// ----------------------------------------------------------------------------
// The table is a row of TABLE_DEPTH cells, one record per cell, kept in table
// order from cell 0. A request that arrives while the block is idle is taken
// at once: every cell compares its id with the key and the match bits are
// registered. Then, as soon as the output register is free, the first match is
// picked, the result is loaded into the output register and the row shifts or
// writes in a single step (insert shifts the tail right, delete shifts it
// left). Print all reads the records out of the row through a one-hot select,
// one record per cycle while the result side does not stall. A new request is
// taken only once the previous one has finished, though a result may still sit
// in the output register waiting to be taken. Records beyond the fill count are
// never read, so the row needs no reset; only the count and control state are
// cleared. Error results carry zero record fields; request codes 6 and 7 are
// dropped without a result.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_record_table #(
    parameter int TABLE_DEPTH = ort_pkg::TABLE_DEPTH_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    ort_req_if.sink    req,
    ort_rsp_if.source  rsp
);
    import ort_pkg::*;

    localparam int IW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = ((CW > POS_W) ? CW : POS_W) + 1;

    // control state
    ctrl_state_t      state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [IW-1:0]    prt_reg, prt_next;
    logic             out_valid_reg, out_valid_next;

    // payload registers
    result_t          out_reg, out_next;
    logic [2:0]       type_reg;
    logic [31:0]      rid_reg, nid_reg;
    logic [63:0]      name_reg, major_reg;
    logic             gender_reg;
    logic [7:0]       age_reg, pos_reg;
    logic [TABLE_DEPTH-1:0] match_reg;

    // cell row
    record_t          cell_rec [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] cell_match;
    cell_cmd_t        cmd;
    logic [IW-1:0]    tgt;

    logic [TABLE_DEPTH-1:0] live;
    logic [TABLE_DEPTH-1:0] first_hit;
    logic [TABLE_DEPTH-1:0] sel;
    logic [IW-1:0]    hit_idx;
    logic             found;
    record_t          sel_rec;
    record_t          new_rec;
    logic             full;
    logic             pos_ok;
    logic             slot_free;
    logic             accept;
    logic             print_last;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            record_t lft, rgt;
            if (g == 0)
            begin : g_first
                assign lft = '0;
            end
            else
            begin : g_mid_l
                assign lft = cell_rec[g-1];
            end
            if (g == TABLE_DEPTH - 1)
            begin : g_last
                assign rgt = '0;
            end
            else
            begin : g_mid_r
                assign rgt = cell_rec[g+1];
            end

            ort_cell #(
                .IDX (g),
                .IW  (IW)
            ) u_cell (
                .clk       (clk),
                .cmd       (cmd),
                .tgt       (tgt),
                .left_rec  (lft),
                .right_rec (rgt),
                .key       (req.record_id),
                .rec       (cell_rec[g]),
                .match     (cell_match[g])
            );
        end
    endgenerate

    // cells holding a record
    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
            live[i] = (CW'(i) < count_reg);
    end

    // first matching cell, one-hot and as an index
    assign first_hit = match_reg & (~match_reg + TABLE_DEPTH'(1));
    assign found     = |match_reg;

    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (first_hit[i])
                hit_idx = hit_idx | IW'(i);
    end

    // single read port of the row: print pointer or first match
    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
            sel[i] = (state_reg == S_PRINT) ? (IW'(i) == prt_reg) : first_hit[i];
    end

    always_comb
    begin
        sel_rec = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (sel[i])
                sel_rec = sel_rec | cell_rec[i];
    end

    assign full       = (count_reg == CW'(TABLE_DEPTH));
    assign pos_ok     = (pos_reg != '0) &&
                        (CMP_W'(pos_reg) <= (CMP_W'(count_reg) + CMP_W'(1)));
    assign slot_free  = !out_valid_reg || rsp.ready;
    assign accept     = req.valid && req.ready;
    assign print_last = ((CW'(prt_reg) + CW'(1)) == count_reg);

    always_comb
    begin
        new_rec.id     = (type_reg == REQ_MODIFY) ? nid_reg : rid_reg;
        new_rec.name   = name_reg;
        new_rec.gender = gender_reg;
        new_rec.age    = age_reg;
        new_rec.major  = major_reg;
    end

    // next state, row command and result
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        prt_next       = prt_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_next       = out_reg;
        cmd.op         = CELL_HOLD;
        cmd.rec        = new_rec;
        tgt            = '0;
        req.ready      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                // unused request codes are dropped here
                if (req.valid && (req.req_type inside {[REQ_APPEND:REQ_PRINT]}))
                    state_next = S_EXEC;
            end

            S_EXEC:
            begin
                if (slot_free)
                begin
                    state_next      = S_IDLE;
                    out_valid_next  = 1'b1;
                    out_next.status = ST_OK;
                    out_next.rec    = '0;
                    out_next.last   = 1'b1;
                    case (type_reg)
                        REQ_APPEND:
                        begin
                            if (full)
                                out_next.status = ST_FULL;
                            else
                            begin
                                cmd.op       = CELL_WRITE;
                                tgt          = IW'(count_reg);
                                count_next   = count_reg + CW'(1);
                                out_next.rec = new_rec;
                            end
                        end
                        REQ_INSERT:
                        begin
                            if (!pos_ok)
                                out_next.status = ST_BAD_POS;
                            else if (full)
                                out_next.status = ST_FULL;
                            else
                            begin
                                cmd.op       = CELL_INSERT;
                                tgt          = IW'(pos_reg - 8'd1);
                                count_next   = count_reg + CW'(1);
                                out_next.rec = new_rec;
                            end
                        end
                        REQ_DELETE:
                        begin
                            if (!found)
                                out_next.status = ST_NOT_FOUND;
                            else
                            begin
                                cmd.op       = CELL_DELETE;
                                tgt          = hit_idx;
                                count_next   = count_reg - CW'(1);
                                out_next.rec = sel_rec;
                            end
                        end
                        REQ_SEARCH:
                        begin
                            if (!found)
                                out_next.status = ST_NOT_FOUND;
                            else
                                out_next.rec = sel_rec;
                        end
                        REQ_MODIFY:
                        begin
                            if (!found)
                                out_next.status = ST_NOT_FOUND;
                            else
                            begin
                                cmd.op       = CELL_WRITE;
                                tgt          = hit_idx;
                                out_next.rec = new_rec;
                            end
                        end
                        REQ_PRINT:
                        begin
                            out_valid_next = out_valid_reg && !rsp.ready;
                            out_next       = out_reg;
                            prt_next       = '0;
                            // empty table gives no result
                            if (count_reg != '0)
                                state_next = S_PRINT;
                        end
                        default:
                        begin
                            out_valid_next = out_valid_reg && !rsp.ready;
                            out_next       = out_reg;
                        end
                    endcase
                end
            end

            S_PRINT:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next.status = ST_OK;
                    out_next.rec    = sel_rec;
                    out_next.last   = print_last;
                    if (print_last)
                        state_next = S_IDLE;
                    else
                        prt_next = prt_reg + IW'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            prt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            prt_reg       <= prt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request capture and registered key compare
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (accept)
        begin
            type_reg   <= req.req_type;
            rid_reg    <= req.record_id;
            nid_reg    <= req.new_id;
            name_reg   <= req.name_token;
            gender_reg <= req.gender_code;
            age_reg    <= req.age_value;
            major_reg  <= req.major_token;
            pos_reg    <= req.position;
            match_reg  <= cell_match & live;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_reg.status;
    assign rsp.out_id     = out_reg.rec.id;
    assign rsp.out_name   = out_reg.rec.name;
    assign rsp.out_gender = out_reg.rec.gender;
    assign rsp.out_age    = out_reg.rec.age;
    assign rsp.out_major  = out_reg.rec.major;
    assign rsp.last_flag  = out_reg.last;

endmodule : ordered_record_table

`default_nettype wire

>>> rtl/ort_cell.sv
// ----------------------------------------------------------------------------
// ort_cell - one slot of the record row
// holds a record, compares its id with the key, shifts to either neighbour
// ----------------------------------------------------------------------------
`default_nettype none

module ort_cell #(
    parameter int IDX = 0,
    parameter int IW  = 4
) (
    input  wire                 clk,
    input  ort_pkg::cell_cmd_t  cmd,
    input  wire [IW-1:0]        tgt,
    input  ort_pkg::record_t    left_rec,
    input  ort_pkg::record_t    right_rec,
    input  wire [31:0]          key,
    output ort_pkg::record_t    rec,
    output logic                match
);
    import ort_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    record_t rec_reg;
    record_t rec_next;

    always_comb
    begin
        rec_next = rec_reg;
        case (cmd.op)
            CELL_WRITE:
            begin
                if (MY_IDX == tgt)
                    rec_next = cmd.rec;
            end
            CELL_INSERT:
            begin
                if (MY_IDX == tgt)
                    rec_next = cmd.rec;
                else if (MY_IDX > tgt)
                    rec_next = left_rec;
            end
            CELL_DELETE:
            begin
                if (MY_IDX >= tgt)
                    rec_next = right_rec;
            end
            default:
            begin
                rec_next = rec_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign rec   = rec_reg;
    assign match = (rec_reg.id == key);

endmodule : ort_cell

`default_nettype wire

>>> test/ordered_record_table_tb.sv
// ----------------------------------------------------------------------------
// ordered_record_table_tb - self-checking bench for the ordered record table
// a mirror of the table predicts every result item from the accepted requests;
// directed corner cases come first, then phased random traffic that grows,
// drains and churns the table, with random gaps on both channels
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_record_table_tb;

    import ort_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;

    // unused request codes, dropped by the block without a result
    localparam logic [2:0] REQ_SPARE_LO = 3'd6;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;

    // cycles with no item moving on either channel before the run is called hung
    localparam int unsigned IDLE_LIMIT = 2000;
    // settle time after the last expected item, print-all being the longest
    localparam int unsigned SETTLE     = 2 * DEPTH + 8;
    localparam int unsigned RANDOM_REQS = 310;

    // one request item as the bench sees it; kind is left wide enough for 6 and 7
    typedef struct {
        logic [2:0]  kind;
        logic [31:0] record_id;
        logic [31:0] new_id;
        logic [63:0] name_token;
        logic        gender_code;
        logic [7:0]  age_value;
        logic [63:0] major_token;
        logic [7:0]  position;
    } request_t;

    // ------------------------------------------------------------------------
    // mirror of the table and the queue of result items it expects
    // ------------------------------------------------------------------------
    class table_mirror;
        record_t     rows [DEPTH];
        int unsigned fill;
        result_t     pending [$];
        int unsigned errors;
        int unsigned checked;
        int unsigned peak;
        int unsigned status_seen [4];

        function new();
            fill    = 0;
            errors  = 0;
            checked = 0;
            peak    = 0;
            foreach (status_seen[i])
                status_seen[i] = 0;
        endfunction

        // error items carry zero record fields
        function void expect_result(status_t st, record_t rec, logic last);
            result_t r;
            r.status = st;
            r.rec    = (st == ST_OK) ? rec : '0;
            r.last   = last;
            pending.push_back(r);
            status_seen[st]++;
        endfunction

        // first row holding the key, or fill when there is none
        function int unsigned find_key(logic [31:0] key);
            int unsigned i;
            for (i = 0; i < fill; i++)
                if (rows[i].id == key)
                    return i;
            return fill;
        endfunction

        function void apply_request(request_t q);
            record_t     fresh;
            int unsigned i;
            int unsigned at;
            fresh.id     = q.record_id;
            fresh.name   = q.name_token;
            fresh.gender = q.gender_code;
            fresh.age    = q.age_value;
            fresh.major  = q.major_token;
            case (q.kind)
                REQ_APPEND:
                begin
                    if (fill >= DEPTH)
                        expect_result(ST_FULL, fresh, 1'b1);
                    else
                    begin
                        rows[fill] = fresh;
                        fill++;
                        expect_result(ST_OK, fresh, 1'b1);
                    end
                end
                REQ_INSERT:
                begin
                    // position is judged before fullness
                    if (int'(q.position) == 0 || int'(q.position) > fill + 1)
                        expect_result(ST_BAD_POS, fresh, 1'b1);
                    else if (fill >= DEPTH)
                        expect_result(ST_FULL, fresh, 1'b1);
                    else
                    begin
                        at = int'(q.position) - 1;
                        for (i = fill; i > at; i--)
                            rows[i] = rows[i - 1];
                        rows[at] = fresh;
                        fill++;
                        expect_result(ST_OK, fresh, 1'b1);
                    end
                end
                REQ_DELETE:
                begin
                    at = find_key(q.record_id);
                    if (at >= fill)
                        expect_result(ST_NOT_FOUND, fresh, 1'b1);
                    else
                    begin
                        expect_result(ST_OK, rows[at], 1'b1);
                        for (i = at; i + 1 < fill; i++)
                            rows[i] = rows[i + 1];
                        fill--;
                    end
                end
                REQ_SEARCH:
                begin
                    at = find_key(q.record_id);
                    if (at >= fill)
                        expect_result(ST_NOT_FOUND, fresh, 1'b1);
                    else
                        expect_result(ST_OK, rows[at], 1'b1);
                end
                REQ_MODIFY:
                begin
                    at = find_key(q.record_id);
                    if (at >= fill)
                        expect_result(ST_NOT_FOUND, fresh, 1'b1);
                    else
                    begin
                        fresh.id = q.new_id;
                        rows[at] = fresh;
                        expect_result(ST_OK, fresh, 1'b1);
                    end
                end
                REQ_PRINT:
                begin
                    for (i = 0; i < fill; i++)
                        expect_result(ST_OK, rows[i], i + 1 == fill);
                end
                default:
                    ;
            endcase
            if (fill > peak)
                peak = fill;
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %h, got %h", field, want, got);
                errors++;
            end
        endfunction

        function void match_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                $error("result item with nothing outstanding: status %0d id %h",
                       got.status, got.rec.id);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            compare_field("status", 64'(want.status), 64'(got.status));
            compare_field("out_id", 64'(want.rec.id), 64'(got.rec.id));
            compare_field("out_name", want.rec.name, got.rec.name);
            compare_field("out_gender", 64'(want.rec.gender), 64'(got.rec.gender));
            compare_field("out_age", 64'(want.rec.age), 64'(got.rec.age));
            compare_field("out_major", want.rec.major, got.rec.major);
            compare_field("last_flag", 64'(want.last), 64'(got.last));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    always #2 clk = ~clk;

    ort_req_if req_ch ();
    ort_rsp_if rsp_ch ();

    ordered_record_table #(
        .TABLE_DEPTH (DEPTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    table_mirror board;
    int unsigned sent = 0;
    int unsigned idle_cycles = 0;
    // when set both sides run flat out, giving stretches with no gaps at all
    bit calm = 1'b0;

    // ids drawn from a small pool so that duplicates and hits are common
    logic [31:0] id_pool [8] = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002,
                                 32'h0000_0007, 32'h8000_0000, 32'h5A5A_5A5A,
                                 32'h0000_00FF, 32'hFFFF_FFFF};

    // mostly no gap, often a short one, now and then a long one
    function automatic int unsigned gap_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] fresh_id();
        if ($urandom_range(0, 1) == 0)
            return id_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    function automatic logic [63:0] fresh_token();
        // short names leave the upper bytes clear
        if ($urandom_range(0, 3) == 0)
            return {32'h0, $urandom};
        return {$urandom, $urandom};
    endfunction

    function automatic request_t make_req(logic [2:0] kind, logic [31:0] id,
                                          logic [31:0] nid, logic [63:0] name,
                                          logic gender, logic [7:0] age,
                                          logic [63:0] major, logic [7:0] pos);
        request_t q;
        q.kind        = kind;
        q.record_id   = id;
        q.new_id      = nid;
        q.name_token  = name;
        q.gender_code = gender;
        q.age_value   = age;
        q.major_token = major;
        q.position    = pos;
        return q;
    endfunction

    // ------------------------------------------------------------------------
    // request side: hold the item until taken, then maybe back off
    // ------------------------------------------------------------------------
    task automatic send_request(input request_t q);
        int unsigned pause;
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= q.kind;
        req_ch.record_id   <= q.record_id;
        req_ch.new_id      <= q.new_id;
        req_ch.name_token  <= q.name_token;
        req_ch.gender_code <= q.gender_code;
        req_ch.age_value   <= q.age_value;
        req_ch.major_token <= q.major_token;
        req_ch.position    <= q.position;
        do
            @(posedge clk);
        while (!req_ch.ready);
        board.apply_request(q);
        sent++;
        pause = gap_len();
        if (pause > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
    endtask

    // phased random traffic: growing phases fill the table to the brim,
    // draining phases empty it, mixed phases churn it
    task automatic run_random(input int unsigned count);
        int unsigned n;
        int unsigned left;
        int unsigned mode;
        int unsigned roll;
        int unsigned pick;
        int unsigned cuts [6];
        request_t    q;
        left = 0;
        mode = 0;
        for (n = 0; n < count; n++)
        begin
            if (left == 0)
            begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(25, 60);
                calm = ($urandom_range(0, 3) == 0);
            end
            left--;
            // cumulative cut points: append, insert, delete, search, modify, print
            case (mode)
                0:       cuts = '{35, 70, 76, 84, 91, 97};
                1:       cuts = '{10, 20, 62, 76, 86, 96};
                default: cuts = '{20, 40, 58, 72, 84, 96};
            endcase
            roll = $urandom_range(0, 99);
            q = make_req(REQ_APPEND, fresh_id(), fresh_id(), fresh_token(),
                         1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                         fresh_token(), 8'd1);
            if (roll < cuts[0])
                q.kind = REQ_APPEND;
            else if (roll < cuts[1])
                q.kind = REQ_INSERT;
            else if (roll < cuts[2])
                q.kind = REQ_DELETE;
            else if (roll < cuts[3])
                q.kind = REQ_SEARCH;
            else if (roll < cuts[4])
                q.kind = REQ_MODIFY;
            else if (roll < cuts[5])
                q.kind = REQ_PRINT;
            else
                q.kind = ($urandom_range(0, 1) == 0) ? REQ_SPARE_LO : REQ_SPARE_HI;
            // lookups mostly aim at a record that is really there
            if (board.fill > 0 && $urandom_range(0, 3) != 0
                && q.kind inside {REQ_DELETE, REQ_SEARCH, REQ_MODIFY})
                q.record_id = board.rows[$urandom_range(0, board.fill - 1)].id;
            // positions mostly in range, some zero, some anywhere
            pick = $urandom_range(0, 9);
            if (pick < 8)
                q.position = 8'($urandom_range(1, board.fill + 1));
            else if (pick == 8)
                q.position = 8'd0;
            else
                q.position = 8'($urandom_range(0, 255));
            send_request(q);
        end
        calm = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // result side: ready held high for a run, then stalled for a gap
    // ------------------------------------------------------------------------
    initial
    begin : result_ready_driver
        int unsigned stall;
        rsp_ch.ready <= 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            stall = gap_len();
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // every result item taken is checked against the oldest expectation
    always @(posedge clk)
    begin : result_monitor
        result_t seen;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            seen.status     = status_t'(rsp_ch.status);
            seen.rec.id     = rsp_ch.out_id;
            seen.rec.name   = rsp_ch.out_name;
            seen.rec.gender = rsp_ch.out_gender;
            seen.rec.age    = rsp_ch.out_age;
            seen.rec.major  = rsp_ch.out_major;
            seen.last       = rsp_ch.last_flag;
            board.match_result(seen);
        end
    end

    // hang detection: count cycles in which no item moves on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : watchdog
        wait (idle_cycles >= IDLE_LIMIT);
        $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_sequence
        board = new();
        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= REQ_APPEND;
        req_ch.record_id   <= '0;
        req_ch.new_id      <= '0;
        req_ch.name_token  <= '0;
        req_ch.gender_code <= 1'b0;
        req_ch.age_value   <= '0;
        req_ch.major_token <= '0;
        req_ch.position    <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: print gives nothing, lookups all miss
        send_request(make_req(REQ_PRINT, 32'h11, 32'h0, 64'h0, 1'b0, 8'd0, 64'h0, 8'd0));
        send_request(make_req(REQ_SEARCH, 32'h11, 32'h0, 64'h0, 1'b0, 8'd0, 64'h0, 8'd0));
        send_request(make_req(REQ_DELETE, 32'h11, 32'h0, 64'h0, 1'b0, 8'd0, 64'h0, 8'd0));
        send_request(make_req(REQ_MODIFY, 32'h11, 32'h12, 64'h6E61_6D65, 1'b1, 8'd30,
                              64'h6D61_6A6F_72, 8'd0));
        // insert into the empty table, then delete its only record
        send_request(make_req(REQ_INSERT, 32'h11, 32'h0, 64'h616E_6E61, 1'b1, 8'd21,
                              64'h6D61_7468, 8'd1));
        send_request(make_req(REQ_DELETE, 32'h11, 32'h0, 64'h0, 1'b0, 8'd0, 64'h0, 8'd0));
        // positions outside 1..count+1
        send_request(make_req(REQ_INSERT, 32'h12, 32'h0, 64'h1, 1'b0, 8'd1, 64'h1, 8'd0));
        send_request(make_req(REQ_INSERT, 32'h12, 32'h0, 64'h1, 1'b0, 8'd1, 64'h1, 8'd2));
        // field extremes, all ones then all zeros
        send_request(make_req(REQ_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, 1'b1, 8'hFF,
                              '1, 8'hFF));
        send_request(make_req(REQ_APPEND, 32'h0, 32'h0, 64'h0, 1'b0, 8'd0, 64'h0, 8'd0));
        // insert at the front, at the end and in the middle, with a duplicate id
        send_request(make_req(REQ_INSERT, 32'h22, 32'h0, 64'h626F_62, 1'b0, 8'd44,
                              64'h6172_74, 8'd1));
        send_request(make_req(REQ_INSERT, 32'h22, 32'h0, 64'h6361_726F_6C, 1'b1, 8'd19,
                              64'h6C61_77, 8'd4));
        send_request(make_req(REQ_INSERT, 32'h33, 32'h0, 64'h6461_7665, 1'b0, 8'd62,
                              64'h6869_7374_6F72_79, 8'd3));
        send_request(make_req(REQ_INSERT, 32'h44, 32'h0, 64'h1, 1'b0, 8'd1, 64'h1, 8'd255));
        // first match wins for search and modify
        send_request(make_req(REQ_SEARCH, 32'h22, 32'h0, 64'h0, 1'b0, 8'd0, 64'h0, 8'd0));
        send_request(make_req(REQ_MODIFY, 32'h22, 32'hFFFF_FFFF, 64'h8877_6655_4433_2211,
                              1'b1, 8'd128, 64'h0102_0304_0506_0708, 8'd0));
        send_request(make_req(REQ_SEARCH, 32'hFFFF_FFFF, 32'h0, 64'h0, 1'b0, 8'd0,
                              64'h0, 8'd0));
        send_request(make_req(REQ_DELETE, 32'h22, 32'h0, 64'h0, 1'b0, 8'd0, 64'h0, 8'd0));
        // spare codes carry content but must leave no trace
        send_request(make_req(REQ_SPARE_LO, 32'h55, 32'h66, '1, 1'b1, 8'd7, '1, 8'd1));
        send_request(make_req(REQ_SPARE_HI, 32'h0, 32'h0, '1, 1'b1, 8'd7, '1, 8'd1));
        send_request(make_req(REQ_PRINT, 32'h0, 32'h0, 64'h0, 1'b0, 8'd0, 64'h0, 8'd0));
        send_request(make_req(REQ_DELETE, 32'h0, 32'h0, 64'h0, 1'b0, 8'd0, 64'h0, 8'd0));

        run_random(RANDOM_REQS);
        req_ch.valid <= 1'b0;

        // drain, then give any stray item time to show up
        while (board.pending.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("%0d requests sent, %0d result items checked, table peaked at %0d of %0d",
                 sent, board.checked, board.peak, DEPTH);
        $display("outcomes: %0d ok, %0d bad position, %0d not found, %0d full",
                 board.status_seen[ST_OK], board.status_seen[ST_BAD_POS],
                 board.status_seen[ST_NOT_FOUND], board.status_seen[ST_FULL]);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule : ordered_record_table_tb

`default_nettype wire
